// ----- sv/mcfr_pkg.sv -----
// Shared types, constants and codes for the multi-channel frame receiver.
`timescale 1ns / 1ps
package mcfr_pkg;

  // Sizing
  localparam int CHANNELS      = 3;
  localparam int PAYLOAD_DEPTH = 256;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PIDX_W   = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W    = $clog2(PAYLOAD_DEPTH + 1);
  localparam int RAM_DEPTH = CHANNELS << PIDX_W;
  localparam int RAM_AW   = $clog2(RAM_DEPTH);
  localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  // Frame constants
  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] SUM_MOD    = 8'd255;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MY_ID        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_ID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRIEND_ID_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRIEND_ID_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEER_COUNT   = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_MY_ID        = 8'd1;
  localparam logic [7:0] RST_BROADCAST_ID = 8'd255;
  localparam logic [7:0] RST_FRIEND_ID_A  = 8'd0;
  localparam logic [7:0] RST_FRIEND_ID_B  = 8'd0;
  localparam logic [7:0] RST_PEER_COUNT   = 8'd0;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SENDER,
    PH_RECEIVER,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

  // Input transaction payload
  typedef struct packed {
    logic       operation;
    logic [1:0] channel;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic        frame_ok;
    logic [7:0]  frame_sender;
    logic [7:0]  frame_receiver;
    logic [7:0]  frame_length;
    logic [7:0]  read_data;
    logic [31:0] frames_received;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0] my_id;
    logic [7:0] broadcast_id;
    logic [7:0] friend_id_a;
    logic [7:0] friend_id_b;
    logic [7:0] peer_count;
  } cfg_t;

  // Classified access, queued between front and back
  typedef struct packed {
    logic              ch_ok;    // channel exists
    logic              is_push;  // push to an existing channel
    logic              rd_ok;    // read of an existing channel, index in range
    logic [CH_W-1:0]   ch;
    logic [7:0]        data_byte;
    logic [PIDX_W-1:0] rd_idx;
  } job_t;

endpackage

// ----- sv/mcfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mcfr_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/mcfr_front.sv -----
// Front end: accepts transactions, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module mcfr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mcfr_pkg::in_item_t in_data_i,
  output logic              job_valid_o,
  output mcfr_pkg::job_t    job_o,
  input  logic              job_pop_i
);
  import mcfr_pkg::*;

  job_t              ent_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  job_t              job_new;
  logic              push, pop;

  // Classify the incoming access
  always_comb begin
    job_new.ch_ok     = int'(in_data_i.channel) < CHANNELS;
    job_new.is_push   = job_new.ch_ok && (in_data_i.operation == OP_PUSH);
    job_new.rd_ok     = job_new.ch_ok && (in_data_i.operation == OP_READ) &&
                        (9'(in_data_i.read_index) < 9'(PAYLOAD_DEPTH));
    job_new.ch        = CH_W'(in_data_i.channel);
    job_new.data_byte = in_data_i.data_byte;
    job_new.rd_idx    = in_data_i.read_index[PIDX_W-1:0];
  end

  assign in_ready_o  = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign job_valid_o = cnt_q != '0;
  assign job_o       = ent_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_pop_i && job_valid_o;

  // Queue pointers and fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= job_new;
    end
  end

endmodule

// ----- sv/mcfr_back.sv -----
// Back end: per-channel frame parsers, payload store and result register.
`timescale 1ns / 1ps
module mcfr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcfr_pkg::cfg_t     cfg_i,
  input  logic               job_valid_i,
  input  mcfr_pkg::job_t     job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mcfr_pkg::out_item_t out_data_o
);
  import mcfr_pkg::*;

  // Per-channel parser state
  phase_e           phase_q [CHANNELS];
  logic [7:0]       sum_q   [CHANNELS];   // running sum, kept modulo 255
  logic [7:0]       exp_q   [CHANNELS];
  logic [CNT_W-1:0] cnt_q   [CHANNELS];
  logic [7:0]       snd_q   [CHANNELS];
  logic [7:0]       rcv_q   [CHANNELS];
  logic [7:0]       len_q   [CHANNELS];
  logic [31:0]      frames_q, frames_d;

  // Selected channel view
  phase_e           cur_phase, phase_d;
  logic [7:0]       cur_sum, sum_d;
  logic [7:0]       cur_exp, exp_d;
  logic [CNT_W-1:0] cur_cnt, cnt_d, cnt_inc;
  logic [7:0]       cur_snd, snd_d;
  logic [7:0]       cur_rcv, rcv_d;
  logic [7:0]       cur_len, len_d;
  logic [8:0]       sum_add;
  logic [7:0]       sum_next;
  logic [7:0]       b;
  logic             sender_ok, receiver_ok, too_long, last_byte, good;

  // Result register
  out_item_t out_q;
  logic      out_valid_q;
  logic      rd_sel_q;
  logic      fire;

  // RAM ports
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;

  assign fire      = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_pop_o = fire;
  assign b         = job_i.data_byte;

  assign cur_phase = phase_q[job_i.ch];
  assign cur_sum   = sum_q[job_i.ch];
  assign cur_exp   = exp_q[job_i.ch];
  assign cur_cnt   = cnt_q[job_i.ch];
  assign cur_snd   = snd_q[job_i.ch];
  assign cur_rcv   = rcv_q[job_i.ch];
  assign cur_len   = len_q[job_i.ch];

  // Header checks and modulo-255 accumulate
  assign sender_ok   = (b == cfg_i.friend_id_a) || (b == cfg_i.friend_id_b) ||
                       ((b != 8'd0) && (b <= cfg_i.peer_count));
  assign receiver_ok = (b == cfg_i.my_id) || (b == cfg_i.broadcast_id);
  assign too_long    = 9'(b) >= 9'(PAYLOAD_DEPTH);
  assign cnt_inc     = cur_cnt + 1'b1;
  assign last_byte   = 9'(cnt_inc) > 9'(cur_exp);
  assign sum_add     = {1'b0, cur_sum} + {1'b0, b};
  assign sum_next    = (sum_add >= {1'b0, SUM_MOD}) ? 8'(sum_add - {1'b0, SUM_MOD})
                                                    : sum_add[7:0];

  // Next parser phase
  always_comb begin
    phase_d = cur_phase;
    case (cur_phase)
      PH_HUNT:     if (b == START_BYTE) phase_d = PH_SENDER;
      PH_SENDER:   phase_d = sender_ok ? PH_RECEIVER : PH_HUNT;
      PH_RECEIVER: phase_d = receiver_ok ? PH_LENGTH : PH_HUNT;
      PH_LENGTH:   phase_d = too_long ? PH_HUNT : PH_PAYLOAD;
      PH_PAYLOAD:  if (last_byte) phase_d = PH_CHECK;
      PH_CHECK:    phase_d = PH_HUNT;
      default:     phase_d = PH_HUNT;
    endcase
  end

  // Parser datapath updates
  always_comb begin
    sum_d  = cur_sum;
    exp_d  = cur_exp;
    cnt_d  = cur_cnt;
    snd_d  = cur_snd;
    rcv_d  = cur_rcv;
    len_d  = cur_len;
    good   = 1'b0;
    ram_we = 1'b0;
    case (cur_phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          sum_d = '0;  // start byte is 0 modulo 255
          exp_d = '0;
          cnt_d = '0;
        end
      end
      PH_SENDER: begin
        snd_d = b;
        if (sender_ok) sum_d = sum_next;
      end
      PH_RECEIVER: begin
        rcv_d = b;
        if (receiver_ok) sum_d = sum_next;
      end
      PH_LENGTH: begin
        len_d = b;
        exp_d = b;
        if (!too_long) sum_d = sum_next;
      end
      PH_PAYLOAD: begin
        sum_d  = sum_next;
        cnt_d  = cnt_inc;
        ram_we = fire && job_i.is_push;
      end
      PH_CHECK: begin
        good = b == cur_sum;
        if (good) sum_d = '0;
      end
      default: ;
    endcase
  end

  assign frames_d = frames_q + 32'(fire && job_i.is_push && good);

  // Parser state write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_q[i] <= PH_HUNT;
        sum_q[i]   <= '0;
        exp_q[i]   <= '0;
        cnt_q[i]   <= '0;
        snd_q[i]   <= '0;
        rcv_q[i]   <= '0;
        len_q[i]   <= '0;
      end
      frames_q <= '0;
    end else if (fire && job_i.is_push) begin
      phase_q[job_i.ch] <= phase_d;
      sum_q[job_i.ch]   <= sum_d;
      exp_q[job_i.ch]   <= exp_d;
      cnt_q[job_i.ch]   <= cnt_d;
      snd_q[job_i.ch]   <= snd_d;
      rcv_q[job_i.ch]   <= rcv_d;
      len_q[job_i.ch]   <= len_d;
      frames_q          <= frames_d;
    end
  end

  // Payload store
  assign ram_waddr = RAM_AW'({job_i.ch, cur_cnt[PIDX_W-1:0]});
  assign ram_raddr = RAM_AW'({job_i.ch, job_i.rd_idx});
  assign ram_re    = fire && job_i.rd_ok;

  mcfr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (b),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register; read data joins from the RAM output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rd_sel_q                <= job_i.rd_ok;
      out_q.frame_ok          <= job_i.is_push && good;
      out_q.frame_sender      <= job_i.ch_ok ? (job_i.is_push ? snd_d : cur_snd) : 8'd0;
      out_q.frame_receiver    <= job_i.ch_ok ? (job_i.is_push ? rcv_d : cur_rcv) : 8'd0;
      out_q.frame_length      <= job_i.ch_ok ? (job_i.is_push ? len_d : cur_len) : 8'd0;
      out_q.read_data         <= 8'd0;
      out_q.frames_received   <= job_i.is_push ? frames_d : frames_q;
    end
  end

  assign out_valid_o = out_valid_q;
  always_comb begin
    out_data_o           = out_q;
    out_data_o.read_data = rd_sel_q ? ram_rdata : 8'd0;
  end

endmodule

// ----- sv/multi_channel_frame_receiver_core.sv -----
// Top level of the multi-channel frame receiver: config registers, front and back ends.
//
//  port group   direction  handshake          payload
//  in_*         input      in_valid/in_ready  in_data_i  (in_item_t)
//  out_*        output     out_valid/ready    out_data_o (out_item_t)
//  cfg_*        input      cfg_we_i only      cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle sustained while out_ready holds; an accepted input passes the
// queue stage, then the parser update plus payload RAM access, before output valid.
// The payload RAM has one write and one registered read port; a push uses the write,
// a read the read port, so no access competes. Reset is asynchronous, active low, and
// clears parser state, headers, the frame counter and the config registers; the payload
// store is not cleared. A two-entry queue lets input keep flowing while a result stalls.
`timescale 1ns / 1ps
module multi_channel_frame_receiver_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  mcfr_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mcfr_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [mcfr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [7:0]                          cfg_wdata_i
);
  import mcfr_pkg::*;

  cfg_t cfg_q;
  job_t job;
  logic job_valid, job_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.my_id        <= RST_MY_ID;
      cfg_q.broadcast_id <= RST_BROADCAST_ID;
      cfg_q.friend_id_a  <= RST_FRIEND_ID_A;
      cfg_q.friend_id_b  <= RST_FRIEND_ID_B;
      cfg_q.peer_count   <= RST_PEER_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MY_ID:        cfg_q.my_id        <= cfg_wdata_i;
        REG_BROADCAST_ID: cfg_q.broadcast_id <= cfg_wdata_i;
        REG_FRIEND_ID_A:  cfg_q.friend_id_a  <= cfg_wdata_i;
        REG_FRIEND_ID_B:  cfg_q.friend_id_b  <= cfg_wdata_i;
        REG_PEER_COUNT:   cfg_q.peer_count   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mcfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  mcfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
